/* sv/euler_rotation_matrix_assert.svh */
// ============================================================================
// Euler rotation matrix assertion macros
// Concurrent check macros shared by the rotation matrix RTL. They expand to
// nothing when SYNTHESIS is defined. The enclosing module must have clk and
// rst_n in scope.
// ============================================================================
`ifndef EULER_ROTATION_MATRIX_ASSERT_SVH
`define EULER_ROTATION_MATRIX_ASSERT_SVH

`ifndef SYNTHESIS

// Implication check: when ante holds, cons must follow (cons may start with ##).
`define ERM_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
        else $error("erm: implication check failed");

// Invariant check: expr holds at every clock edge outside reset.
`define ERM_ASSERT_ALWAYS(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("erm: invariant check failed");

`else

`define ERM_ASSERT_IMP(label, ante, cons)
`define ERM_ASSERT_ALWAYS(label, expr)

`endif

`endif

/* sv/erm_pkg.sv */
// ============================================================================
// Euler rotation matrix package
// Widths, CORDIC constants and pipeline depths shared by the rotation matrix
// modules.
// ============================================================================
`default_nettype none

package erm_pkg;

    // Angle input: binary fraction of a full turn.
    localparam int ANGLE_W    = 16;
    localparam int ANGLE_BITS = 16;
    localparam int ANGLE_SHIFT = 32 - ANGLE_BITS;
    localparam logic [31:0] ANGLE_MASK = 32'((64'd1 << ANGLE_BITS) - 64'd1);

    // Matrix entry output: signed fixed point with FRAC_BITS fraction bits.
    localparam int ENTRY_W   = 16;
    localparam int FRAC_BITS = 14;

    // Internal trig values are Q30 in 32 bits.
    localparam int TRIG_W = 32;
    typedef logic signed [TRIG_W-1:0] trig_t;

    typedef struct packed {
        trig_t c;
        trig_t s;
    } sincos_t;

    localparam int    CORDIC_STEPS = 28;
    localparam trig_t Q30_ONE      = 32'sd1073741824;
    localparam trig_t CORDIC_GAIN  = 32'sd652032874;

    // Arctangent of 2^-i in units of 2^-32 turn.
    localparam trig_t ATAN_TABLE [CORDIC_STEPS] = '{
        32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
        32'sd42667331,  32'sd21354465,  32'sd10679838,  32'sd5340245,
        32'sd2670163,   32'sd1335087,   32'sd667544,    32'sd333772,
        32'sd166886,    32'sd83443,     32'sd41722,     32'sd20861,
        32'sd10430,     32'sd5215,      32'sd2608,      32'sd1304,
        32'sd652,       32'sd326,       32'sd163,       32'sd81,
        32'sd41,        32'sd20,        32'sd10,        32'sd5
    };

    // One register per CORDIC iteration plus the quadrant fold-out register.
    localparam int CORDIC_LAT = CORDIC_STEPS + 1;
    // Two multiply stages, a sum stage and a rounding stage follow.
    localparam int LATENCY    = CORDIC_LAT + 4;

endpackage

`default_nettype wire

/* sv/erm_cordic.sv */
// ============================================================================
// Pipelined CORDIC sine and cosine
// One rotation per register stage over the first-quadrant phase, followed
// by a clamp and quadrant fold-out stage.
// ============================================================================
`default_nettype none

module erm_cordic
    import erm_pkg::*;
(
    input  logic               clk,
    input  logic [ANGLE_W-1:0] angle,
    output sincos_t            trig
);

    logic [31:0] phase;

    trig_t      x_in   [CORDIC_STEPS];
    trig_t      y_in   [CORDIC_STEPS];
    trig_t      z_in   [CORDIC_STEPS];
    logic [1:0] q_in   [CORDIC_STEPS];

    trig_t      x_next [CORDIC_STEPS];
    trig_t      y_next [CORDIC_STEPS];
    trig_t      z_next [CORDIC_STEPS];

    trig_t      x_reg  [CORDIC_STEPS];
    trig_t      y_reg  [CORDIC_STEPS];
    trig_t      z_reg  [CORDIC_STEPS];
    logic [1:0] q_reg  [CORDIC_STEPS];

    trig_t      x_cl;
    trig_t      y_cl;
    sincos_t    trig_next;
    sincos_t    trig_reg;

    assign phase = (32'(angle) & ANGLE_MASK) << ANGLE_SHIFT;

    // Stage inputs: the first stage starts from the gain on the x axis.
    always_comb
    begin
        x_in[0] = CORDIC_GAIN;
        y_in[0] = '0;
        z_in[0] = {2'b00, phase[29:0]};
        q_in[0] = phase[31:30];
        for (int k = 1; k < CORDIC_STEPS; k++)
        begin
            x_in[k] = x_reg[k-1];
            y_in[k] = y_reg[k-1];
            z_in[k] = z_reg[k-1];
            q_in[k] = q_reg[k-1];
        end
    end

    always_comb
    begin
        for (int k = 0; k < CORDIC_STEPS; k++)
        begin
            if (z_in[k] >= 0)
            begin
                x_next[k] = x_in[k] - (y_in[k] >>> k);
                y_next[k] = y_in[k] + (x_in[k] >>> k);
                z_next[k] = z_in[k] - ATAN_TABLE[k];
            end
            else
            begin
                x_next[k] = x_in[k] + (y_in[k] >>> k);
                y_next[k] = y_in[k] - (x_in[k] >>> k);
                z_next[k] = z_in[k] + ATAN_TABLE[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < CORDIC_STEPS; k++)
        begin
            x_reg[k] <= x_next[k];
            y_reg[k] <= y_next[k];
            z_reg[k] <= z_next[k];
            q_reg[k] <= q_in[k];
        end
    end

    // Clamp to plus or minus one, then unfold the quadrant.
    always_comb
    begin
        x_cl = x_reg[CORDIC_STEPS-1];
        y_cl = y_reg[CORDIC_STEPS-1];
        if (x_cl > Q30_ONE)
        begin
            x_cl = Q30_ONE;
        end
        else if (x_cl < -Q30_ONE)
        begin
            x_cl = -Q30_ONE;
        end
        if (y_cl > Q30_ONE)
        begin
            y_cl = Q30_ONE;
        end
        else if (y_cl < -Q30_ONE)
        begin
            y_cl = -Q30_ONE;
        end
        case (q_reg[CORDIC_STEPS-1])
            2'd0:
            begin
                trig_next.c = x_cl;
                trig_next.s = y_cl;
            end
            2'd1:
            begin
                trig_next.c = -y_cl;
                trig_next.s = x_cl;
            end
            2'd2:
            begin
                trig_next.c = -x_cl;
                trig_next.s = -y_cl;
            end
            default:
            begin
                trig_next.c = y_cl;
                trig_next.s = -x_cl;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        trig_reg <= trig_next;
    end

    assign trig = trig_reg;

endmodule

`default_nettype wire

/* sv/euler_rotation_matrix.sv */
// ============================================================================
// Euler angle rotation matrix
// Streams angle triples through three CORDIC pipelines and a product tree,
// giving the 3x3 rotation part of Rz * Ry * Rx in signed fixed point.
// ============================================================================
// A transaction accepted at a rising edge with start high gives done after
// 28 CORDIC stages, fold-out, two multiply stages, a sum stage and a rounding
// stage. Throughput: one transaction per cycle; busy is always low and the
// receiver cannot stall the results.
// Reset clears only the valid pipeline; no transaction is in flight after it.
`default_nettype none

`include "euler_rotation_matrix_assert.svh"

module euler_rotation_matrix
    import erm_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [ANGLE_W-1:0]        angle_x,
    input  logic [ANGLE_W-1:0]        angle_y,
    input  logic [ANGLE_W-1:0]        angle_z,
    output logic                      done,
    output logic signed [ENTRY_W-1:0] r0c0,
    output logic signed [ENTRY_W-1:0] r0c1,
    output logic signed [ENTRY_W-1:0] r0c2,
    output logic signed [ENTRY_W-1:0] r1c0,
    output logic signed [ENTRY_W-1:0] r1c1,
    output logic signed [ENTRY_W-1:0] r1c2,
    output logic signed [ENTRY_W-1:0] r2c0,
    output logic signed [ENTRY_W-1:0] r2c1,
    output logic signed [ENTRY_W-1:0] r2c2
);

    // The rounding stage drops 30 - FRAC_BITS bits with round half up and
    // then saturates to plus or minus one.
    localparam int FIN_SHIFT = 30 - FRAC_BITS;
    localparam logic signed [33:0] FIN_RND =
        (FIN_SHIFT > 0) ? (34'sd1 <<< ((FIN_SHIFT > 0) ? FIN_SHIFT - 1 : 0)) : 34'sd0;
    localparam logic signed [33:0] FIN_LIM = 34'sd1 <<< FRAC_BITS;
    localparam logic signed [63:0] QMUL_RND = 64'sd536870912;

    // Q30 times Q30, rounded back to Q30. Both operands are within plus or
    // minus one, so the result fits the trig width.
    function automatic trig_t qmul(input trig_t a, input trig_t b);
        logic signed [63:0] p;
        p = (64'(a) * 64'(b) + QMUL_RND) >>> 30;
        return p[TRIG_W-1:0];
    endfunction

    function automatic logic [ENTRY_W-1:0] finish_q(input logic signed [32:0] v);
        logic signed [33:0] r;
        r = (34'(v) + FIN_RND) >>> FIN_SHIFT;
        if (r > FIN_LIM)
        begin
            r = FIN_LIM;
        end
        else if (r < -FIN_LIM)
        begin
            r = -FIN_LIM;
        end
        return r[ENTRY_W-1:0];
    endfunction

    // ------------------------------------------------------------------
    // Valid pipeline: one bit per register stage, the only reset state.
    // ------------------------------------------------------------------
    logic [LATENCY-1:0] vld_reg;
    logic [LATENCY-1:0] vld_next;

    assign vld_next = {vld_reg[LATENCY-2:0], start};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // The pipeline never holds off a new transaction.
    assign busy = 1'b0;
    assign done = vld_reg[LATENCY-1];

    // ------------------------------------------------------------------
    // Sine and cosine of each angle.
    // ------------------------------------------------------------------
    sincos_t sc_x;
    sincos_t sc_y;
    sincos_t sc_z;

    erm_cordic u_cordic_x
    (
        .clk   (clk),
        .angle (angle_x),
        .trig  (sc_x)
    );

    erm_cordic u_cordic_y
    (
        .clk   (clk),
        .angle (angle_y),
        .trig  (sc_y)
    );

    erm_cordic u_cordic_z
    (
        .clk   (clk),
        .angle (angle_z),
        .trig  (sc_z)
    );

    // ------------------------------------------------------------------
    // First multiply stage: all single products, including the two shared
    // partial terms cz*sy and sz*sy of the middle and right column expansions.
    // ------------------------------------------------------------------
    trig_t czcy_reg;
    trig_t szcx_reg;
    trig_t szsx_reg;
    trig_t szcy_reg;
    trig_t czcx_reg;
    trig_t czsx_reg;
    trig_t cysx_reg;
    trig_t cycx_reg;
    trig_t czsy_reg;
    trig_t szsy_reg;
    trig_t sy1_reg;
    trig_t sx1_reg;
    trig_t cx1_reg;

    always_ff @(posedge clk)
    begin
        czcy_reg <= qmul(sc_z.c, sc_y.c);
        szcx_reg <= qmul(sc_z.s, sc_x.c);
        szsx_reg <= qmul(sc_z.s, sc_x.s);
        szcy_reg <= qmul(sc_z.s, sc_y.c);
        czcx_reg <= qmul(sc_z.c, sc_x.c);
        czsx_reg <= qmul(sc_z.c, sc_x.s);
        cysx_reg <= qmul(sc_y.c, sc_x.s);
        cycx_reg <= qmul(sc_y.c, sc_x.c);
        czsy_reg <= qmul(sc_z.c, sc_y.s);
        szsy_reg <= qmul(sc_z.s, sc_y.s);
        sy1_reg  <= sc_y.s;
        sx1_reg  <= sc_x.s;
        cx1_reg  <= sc_x.c;
    end

    // ------------------------------------------------------------------
    // Second multiply stage: the nested products, rounded again.
    // ------------------------------------------------------------------
    trig_t czcy2_reg;
    trig_t szcx2_reg;
    trig_t szsx2_reg;
    trig_t szcy2_reg;
    trig_t czcx2_reg;
    trig_t czsx2_reg;
    trig_t cysx2_reg;
    trig_t cycx2_reg;
    trig_t sy2_reg;
    trig_t czsysx_reg;
    trig_t czsycx_reg;
    trig_t szsysx_reg;
    trig_t szsycx_reg;

    always_ff @(posedge clk)
    begin
        czcy2_reg  <= czcy_reg;
        szcx2_reg  <= szcx_reg;
        szsx2_reg  <= szsx_reg;
        szcy2_reg  <= szcy_reg;
        czcx2_reg  <= czcx_reg;
        czsx2_reg  <= czsx_reg;
        cysx2_reg  <= cysx_reg;
        cycx2_reg  <= cycx_reg;
        sy2_reg    <= sy1_reg;
        czsysx_reg <= qmul(czsy_reg, sx1_reg);
        czsycx_reg <= qmul(czsy_reg, cx1_reg);
        szsysx_reg <= qmul(szsy_reg, sx1_reg);
        szsycx_reg <= qmul(szsy_reg, cx1_reg);
    end

    // ------------------------------------------------------------------
    // Sum stage: exact sums, one bit wider than the products. Entries are
    // kept in row-major order.
    // ------------------------------------------------------------------
    logic signed [32:0] sum_reg [9];

    always_ff @(posedge clk)
    begin
        sum_reg[0] <= 33'(czcy2_reg);
        sum_reg[1] <= -33'(szcx2_reg) - 33'(czsysx_reg);
        sum_reg[2] <= 33'(szsx2_reg) - 33'(czsycx_reg);
        sum_reg[3] <= 33'(szcy2_reg);
        sum_reg[4] <= 33'(czcx2_reg) - 33'(szsysx_reg);
        sum_reg[5] <= -33'(czsx2_reg) - 33'(szsycx_reg);
        sum_reg[6] <= 33'(sy2_reg);
        sum_reg[7] <= 33'(cysx2_reg);
        sum_reg[8] <= 33'(cycx2_reg);
    end

    // ------------------------------------------------------------------
    // Rounding stage: round half up to the output precision and saturate.
    // These registers drive the result ports directly.
    // ------------------------------------------------------------------
    logic [ENTRY_W-1:0] fin_reg [9];

    always_ff @(posedge clk)
    begin
        for (int e = 0; e < 9; e++)
        begin
            fin_reg[e] <= finish_q(sum_reg[e]);
        end
    end

    assign r0c0 = fin_reg[0];
    assign r0c1 = fin_reg[1];
    assign r0c2 = fin_reg[2];
    assign r1c0 = fin_reg[3];
    assign r1c1 = fin_reg[4];
    assign r1c2 = fin_reg[5];
    assign r2c0 = fin_reg[6];
    assign r2c1 = fin_reg[7];
    assign r2c2 = fin_reg[8];

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    logic trig_y_ok;

    assign trig_y_ok = (sc_y.s <= Q30_ONE) && (sc_y.s >= -Q30_ONE) &&
                       (sc_y.c <= Q30_ONE) && (sc_y.c >= -Q30_ONE);

    // Every accepted transaction comes out after the fixed pipeline depth.
    `ERM_ASSERT_IMP(a_fixed_latency, start, ##LATENCY done)
    // No result appears without a transaction accepted that long before.
    `ERM_ASSERT_IMP(a_no_spurious_done, done, $past(start, LATENCY))
    // The y-angle trig values leaving the CORDIC are clamped to plus or minus one.
    `ERM_ASSERT_IMP(a_trig_clamped, vld_reg[CORDIC_LAT], trig_y_ok)

endmodule

`default_nettype wire

/* verif/erm_matrix_checker.sv */
// ============================================================================
// Rotation matrix checker
// Watches the angle and matrix channels of the rotation matrix block. It
// predicts each matrix from its accepted angle triple and compares every
// entry of each result in order of arrival.
// ============================================================================
module erm_matrix_checker
    import erm_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic                      busy,
    input  logic [ANGLE_W-1:0]        angle_x,
    input  logic [ANGLE_W-1:0]        angle_y,
    input  logic [ANGLE_W-1:0]        angle_z,
    input  logic                      done,
    input  logic signed [ENTRY_W-1:0] r0c0,
    input  logic signed [ENTRY_W-1:0] r0c1,
    input  logic signed [ENTRY_W-1:0] r0c2,
    input  logic signed [ENTRY_W-1:0] r1c0,
    input  logic signed [ENTRY_W-1:0] r1c1,
    input  logic signed [ENTRY_W-1:0] r1c2,
    input  logic signed [ENTRY_W-1:0] r2c0,
    input  logic signed [ENTRY_W-1:0] r2c1,
    input  logic signed [ENTRY_W-1:0] r2c2,
    output int                        mismatch_count,
    output int                        matrices_checked,
    output int                        matrices_pending
);

    timeunit 1ns;
    timeprecision 1ps;

    // Entry 3*row + column.
    typedef logic [8:0][ENTRY_W-1:0] matrix_t;

    typedef struct {
        longint c;
        longint s;
    } trig_pair_t;

    localparam int     ROT_STEPS = 28;
    localparam longint UNIT_Q30  = longint'(1) << 30;
    localparam longint ROT_GAIN  = 64'sd652032874;

    // Arctangent of 2^-i, in units of 2^-32 of a turn.
    localparam longint TURN_ATAN [ROT_STEPS] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
        41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10, 5
    };

    matrix_t pending_matrices [$];
    matrix_t want;
    matrix_t got;
    int      errs;
    int      checked;

    function automatic longint clamp_unit(longint v);
        if (v > UNIT_Q30)
            return UNIT_Q30;
        if (v < -UNIT_Q30)
            return -UNIT_Q30;
        return v;
    endfunction

    // Cosine and sine in Q30, by rotation in the first quadrant and fold-out.
    function automatic trig_pair_t angle_trig(logic [ANGLE_W-1:0] angle);
        logic [31:0] phase;
        logic [1:0]  quad;
        longint      x;
        longint      y;
        longint      z;
        longint      nx;
        longint      ny;
        trig_pair_t  tp;
        // Truncating to 32 bits drops any angle bits above ANGLE_BITS.
        phase = 32'(longint'(angle) << (32 - ANGLE_BITS));
        quad  = phase[31:30];
        z     = longint'(phase & 32'h3FFF_FFFF);
        x     = ROT_GAIN;
        y     = 0;
        for (int i = 0; i < ROT_STEPS; i++)
        begin
            if (z >= 0)
            begin
                nx = x - (y >>> i);
                ny = y + (x >>> i);
                z  = z - TURN_ATAN[i];
            end
            else
            begin
                nx = x + (y >>> i);
                ny = y - (x >>> i);
                z  = z + TURN_ATAN[i];
            end
            x = nx;
            y = ny;
        end
        x = clamp_unit(x);
        y = clamp_unit(y);
        case (quad)
            2'd0:
            begin
                tp.c = x;
                tp.s = y;
            end
            2'd1:
            begin
                tp.c = -y;
                tp.s = x;
            end
            2'd2:
            begin
                tp.c = -x;
                tp.s = -y;
            end
            default:
            begin
                tp.c = y;
                tp.s = -x;
            end
        endcase
        return tp;
    endfunction

    // Q30 product, rounded half up.
    function automatic longint q30_mul(longint a, longint b);
        return (a * b + (longint'(1) << 29)) >>> 30;
    endfunction

    // Q30 sum to an output entry: round half up, saturate, keep the low bits.
    function automatic logic [ENTRY_W-1:0] to_entry(longint v);
        longint r;
        longint lim;
        lim = longint'(1) << FRAC_BITS;
        r   = v;
        if (FRAC_BITS < 30)
            r = (v + (longint'(1) << (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
        if (r > lim)
            r = lim;
        if (r < -lim)
            r = -lim;
        return r[ENTRY_W-1:0];
    endfunction

    function automatic matrix_t rotation_matrix_zyx(logic [ANGLE_W-1:0] ax,
                                                    logic [ANGLE_W-1:0] ay,
                                                    logic [ANGLE_W-1:0] az);
        trig_pair_t tx;
        trig_pair_t ty;
        trig_pair_t tz;
        longint     czsy;
        longint     szsy;
        matrix_t    m;
        tx   = angle_trig(ax);
        ty   = angle_trig(ay);
        tz   = angle_trig(az);
        czsy = q30_mul(tz.c, ty.s);
        szsy = q30_mul(tz.s, ty.s);
        m[0] = to_entry(q30_mul(tz.c, ty.c));
        m[1] = to_entry(-q30_mul(tz.s, tx.c) - q30_mul(czsy, tx.s));
        m[2] = to_entry(q30_mul(tz.s, tx.s) - q30_mul(czsy, tx.c));
        m[3] = to_entry(q30_mul(tz.s, ty.c));
        m[4] = to_entry(q30_mul(tz.c, tx.c) - q30_mul(szsy, tx.s));
        m[5] = to_entry(-q30_mul(tz.c, tx.s) - q30_mul(szsy, tx.c));
        m[6] = to_entry(ty.s);
        m[7] = to_entry(q30_mul(ty.c, tx.s));
        m[8] = to_entry(q30_mul(ty.c, tx.c));
        return m;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_matrices.delete();
            errs             = 0;
            checked          = 0;
            mismatch_count   <= 0;
            matrices_checked <= 0;
            matrices_pending <= 0;
        end
        else
        begin
            if (done)
            begin
                got = {r2c2, r2c1, r2c0, r1c2, r1c1, r1c0, r0c2, r0c1, r0c0};
                if (pending_matrices.size() == 0)
                begin
                    $error("matrix result with no transaction outstanding");
                    errs++;
                end
                else
                begin
                    want = pending_matrices.pop_front();
                    for (int i = 0; i < 9; i++)
                    begin
                        if (got[i] !== want[i])
                        begin
                            $error("%s: expected %0d, actual %0d",
                                   $sformatf("r%0dc%0d", i / 3, i % 3),
                                   $signed(want[i]), $signed(got[i]));
                            errs++;
                        end
                    end
                    checked++;
                end
            end
            if (start && !busy)
                pending_matrices.push_back(rotation_matrix_zyx(angle_x, angle_y, angle_z));
            mismatch_count   <= errs;
            matrices_checked <= checked;
            matrices_pending <= pending_matrices.size();
        end
    end

endmodule

/* verif/tb_euler_rotation_matrix.sv */
// ============================================================================
// Euler rotation matrix testbench
// Drives angle triples into the rotation matrix block, directed corners first
// and then random triples under three sender idle profiles. A checker beside
// the block predicts every matrix and compares it entry by entry.
// ============================================================================
module tb_euler_rotation_matrix;

    import erm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Cycles with no transaction on either channel before the run is declared
    // hung. The longest legal quiet stretch is a sender gap or one pipeline
    // drain plus the final settle, all well below this.
    localparam int STALL_LIMIT  = 1000;
    localparam int RANDOM_ITEMS = 800;
    localparam int N_DIRECTED   = 20;

    // Directed triples, packed as {angle_x, angle_y, angle_z}. They cover zero
    // and all-ones angles, every quadrant boundary and its neighbors, the
    // half-quadrant point, toggling bit patterns, and the gimbal positions
    // where the sine of the y angle is exactly plus or minus one.
    localparam logic [47:0] DIRECTED [N_DIRECTED] = '{
        {16'h0000, 16'h0000, 16'h0000},
        {16'hFFFF, 16'hFFFF, 16'hFFFF},
        {16'h4000, 16'h0000, 16'h0000},
        {16'h0000, 16'h4000, 16'h0000},
        {16'h0000, 16'h0000, 16'h4000},
        {16'h8000, 16'h8000, 16'h8000},
        {16'hC000, 16'hC000, 16'hC000},
        {16'h3FFF, 16'h7FFF, 16'hBFFF},
        {16'h4001, 16'h8001, 16'hC001},
        {16'h2000, 16'h2000, 16'h2000},
        {16'hE000, 16'h6000, 16'hA000},
        {16'hAAAA, 16'h5555, 16'hAAAA},
        {16'h5555, 16'hAAAA, 16'h5555},
        {16'h0001, 16'h0001, 16'h0001},
        {16'hFFFF, 16'h0000, 16'h0001},
        {16'h0000, 16'hC000, 16'h8000},
        {16'h1234, 16'h4000, 16'h5678},
        {16'h8000, 16'h0000, 16'h4000},
        {16'hFF00, 16'h00FF, 16'h0F0F},
        {16'h7FFF, 16'hC001, 16'h3FFF}
    };

    logic               clk     = 1'b0;
    logic               rst_n   = 1'b0;
    logic               start   = 1'b0;
    logic [ANGLE_W-1:0] angle_x = '0;
    logic [ANGLE_W-1:0] angle_y = '0;
    logic [ANGLE_W-1:0] angle_z = '0;

    logic                      busy;
    logic                      done;
    logic signed [ENTRY_W-1:0] r0c0, r0c1, r0c2;
    logic signed [ENTRY_W-1:0] r1c0, r1c1, r1c2;
    logic signed [ENTRY_W-1:0] r2c0, r2c1, r2c2;

    int mismatch_count;
    int matrices_checked;
    int matrices_pending;

    // Percentage of cycles in which the sender idles.
    int sender_idle_pct = 0;
    int triples_sent    = 0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    euler_rotation_matrix dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .angle_x (angle_x),
        .angle_y (angle_y),
        .angle_z (angle_z),
        .done    (done),
        .r0c0    (r0c0),
        .r0c1    (r0c1),
        .r0c2    (r0c2),
        .r1c0    (r1c0),
        .r1c1    (r1c1),
        .r1c2    (r1c2),
        .r2c0    (r2c0),
        .r2c1    (r2c1),
        .r2c2    (r2c2)
    );

    erm_matrix_checker matrix_check (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .angle_x          (angle_x),
        .angle_y          (angle_y),
        .angle_z          (angle_z),
        .done             (done),
        .r0c0             (r0c0),
        .r0c1             (r0c1),
        .r0c2             (r0c2),
        .r1c0             (r1c0),
        .r1c1             (r1c1),
        .r1c2             (r1c2),
        .r2c0             (r2c0),
        .r2c1             (r2c1),
        .r2c2             (r2c2),
        .mismatch_count   (mismatch_count),
        .matrices_checked (matrices_checked),
        .matrices_pending (matrices_pending)
    );

    // Random angle. A fifth of the draws land within a few codes of a
    // quadrant boundary, where the CORDIC output clamps and the rounded
    // entries are most likely to reach plus or minus one.
    function automatic logic [ANGLE_W-1:0] random_angle();
        logic [ANGLE_W-1:0] a;
        if ($urandom_range(9) < 2)
            a = {2'($urandom_range(3)), 14'd0} + ANGLE_W'($urandom_range(8)) - 16'd4;
        else
            a = ANGLE_W'($urandom);
        return a;
    endfunction

    // Offers one triple and returns after the edge that accepts it. Before
    // offering, the sender idles in each cycle with the profile's chance, so
    // that share of all cycles carries no transaction. start stays high on
    // return so back-to-back transactions need no extra edge.
    task automatic send_triple(input logic [ANGLE_W-1:0] ax,
                               input logic [ANGLE_W-1:0] ay,
                               input logic [ANGLE_W-1:0] az);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start   <= 1'b1;
        angle_x <= ax;
        angle_y <= ay;
        angle_z <= az;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        triples_sent++;
    endtask

    // Stops offering and waits until every outstanding matrix has arrived.
    // The registered pending count of the checker lags the edge, which is safe
    // since a transaction accepted at an edge shows in the count at the next.
    task automatic drain_pipeline();
        start <= 1'b0;
        do
            @(posedge clk);
        while (matrices_pending != 0);
    endtask

    // Watchdog: ends the run if neither channel moves for too long.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((start && !busy) || done)
                quiet = 0;
            else
                quiet++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin : stimulus
        int per_phase;
        per_phase = RANDOM_ITEMS / 3;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed corners, sent back to back with the sender never idle.
        sender_idle_pct = 0;
        for (int i = 0; i < N_DIRECTED; i++)
            send_triple(DIRECTED[i][47:32], DIRECTED[i][31:16], DIRECTED[i][15:0]);
        drain_pipeline();

        // Random triples: a lightly idle sender, then a mostly idle one, then
        // a sender that never idles so the pipeline runs full. Between phases
        // the sender holds off until the pipeline is empty.
        for (int phase = 0; phase < 3; phase++)
        begin
            sender_idle_pct = (phase == 0) ? 23 : (phase == 1) ? 84 : 0;
            for (int n = 0; n < per_phase; n++)
                send_triple(random_angle(), random_angle(), random_angle());
            drain_pipeline();
        end

        // Any stray result would leave the pipeline during this wait; the checker
        // flags it as unexpected.
        repeat (LATENCY + 8) @(posedge clk);

        $display("Covered %0d angle triples (%0d directed corners, the rest random).",
                 triples_sent, N_DIRECTED);
        $display("Sender idle profiles 23%%, 84%% and none; %0d matrices compared.",
                 matrices_checked);
        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

/* euler_rotation_matrix.f */
+incdir+sv
sv/erm_pkg.sv
sv/erm_cordic.sv
sv/euler_rotation_matrix.sv
verif/erm_matrix_checker.sv
verif/tb_euler_rotation_matrix.sv
